### sv/iffd_pkg.sv
`default_nettype none

package iffd_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned LEN_W       = LENGTH_BITS;
  localparam int unsigned POS_W       = 33;
  localparam int unsigned NEXT_W      = 34;
  localparam int unsigned OFFS_W      = 33;

  localparam logic [31:0] TAG_FORM = 32'h464F_524D;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_CAT  = 32'h4341_5420;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_CHUNK    = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  localparam logic [LEN_W-1:0] MIN_FILE_LEN  = LEN_W'(8);
  localparam logic [LEN_W-1:0] TYPED_HDR_LEN = LEN_W'(12);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        record_kind;
    logic [31:0]       tag_word;
    logic [31:0]       size_word;
    logic [31:0]       form_type;
    logic              type_present;
    logic [OFFS_W-1:0] data_offset;
  } out_item_t;

endpackage

`default_nettype wire

### sv/iff_chunk_deframer.sv
// IFF-85 chunk deframer.
// Write the file length on the cfg channel (cfg_valid_i/cfg_ready_o/cfg_wdata_i)
// while no file is in flight; cfg_ready_o is always high.
// Feed the file one byte per transfer on the input channel; set first_byte on
// byte 0 of each file to restart the parse. The output channel gives header,
// chunk and rejected records, at most one per input byte.
// A record appears on out_valid_o once the byte that completes it has passed
// the input register and then the result register.
// Throughput: one byte per cycle while in_stall_o is low; the parse state is
// updated by one compare and add stage per byte.
// When the receiver stalls, one further record parks in a skid stage; the
// input register then fills and in_stall_o rises until the output drains.
// Bytes that complete no record pass without touching the output.
// Reset clears the parse state, the file length and both channels' valids;
// bytes before the first marked byte, or after the parse ends, are dropped.
`default_nettype none

module iff_chunk_deframer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [31:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  iffd_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output iffd_pkg::out_item_t   out_item_o
);
  import iffd_pkg::*;

  logic      a_valid_q;
  in_item_t  a_item_q;
  logic      full;
  logic      step;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready_o = 1'b1;
  assign step        = a_valid_q && !full;
  assign in_stall_o  = a_valid_q && full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) a_item_q <= in_item_i;
  end

  iffd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (a_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  iffd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res_valid),
    .push_item_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### sv/iffd_parse.sv
`default_nettype none

module iffd_parse (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [31:0]      cfg_wdata_i,
  input  wire logic             step_i,
  input  iffd_pkg::in_item_t    item_i,
  output logic                  res_valid_o,
  output iffd_pkg::out_item_t   res_o
);
  import iffd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAG,
    PH_HEADER,
    PH_SCAN
  } phase_e;

  phase_e            phase_q, phase_d, phase_w;
  logic              fin_q, fin_d;
  logic [POS_W-1:0]  pos_q, pos_d, pos_n;
  logic [NEXT_W-1:0] next_q, next_d;
  logic [31:0]       gather_q, gather_d, gather_n;
  logic [31:0]       tag_q, tag_d;
  logic [31:0]       size_q, size_d;
  logic [LEN_W-1:0]  len_q;
  logic              active;

  logic [NEXT_W:0]   next_p3, next_p7, next_p8, new_next, new_next_p8;
  logic [NEXT_W:0]   pos_ext, len_ext;

  assign next_p3     = {1'b0, next_q} + (NEXT_W+1)'(3);
  assign next_p7     = {1'b0, next_q} + (NEXT_W+1)'(7);
  assign next_p8     = {1'b0, next_q} + (NEXT_W+1)'(8);
  assign new_next    = next_p8 + (NEXT_W+1)'(gather_n);
  assign new_next_p8 = new_next + (NEXT_W+1)'(8);
  assign pos_ext     = (NEXT_W+1)'(pos_n);
  assign len_ext     = (NEXT_W+1)'(len_q);

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    pos_d       = pos_q;
    next_d      = next_q;
    gather_d    = gather_q;
    tag_d       = tag_q;
    size_d      = size_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    phase_w     = phase_q;
    pos_n       = pos_q + POS_W'(1);
    active      = 1'b0;

    if (item_i.first_byte) begin
      phase_w = PH_TAG;
      pos_n   = '0;
      active  = 1'b1;
    end else if (phase_q != PH_IDLE && !fin_q) begin
      active = 1'b1;
    end

    gather_n = item_i.first_byte ? {24'd0, item_i.data_byte}
                                 : {gather_q[23:0], item_i.data_byte};

    if (step_i && active) begin
      pos_d    = pos_n;
      gather_d = gather_n;
      // restart the parse on the first byte of a file
      if (item_i.first_byte) begin
        phase_d = PH_TAG;
        fin_d   = 1'b0;
        next_d  = '0;
        tag_d   = '0;
        size_d  = '0;
      end
      case (phase_w)
        PH_TAG: begin
          if (pos_n == '0 && len_q < MIN_FILE_LEN) begin
            fin_d                = 1'b1;
            res_valid_o          = 1'b1;
            res_o.record_kind    = KIND_REJECTED;
          end else if (pos_n == POS_W'(3)) begin
            if (gather_n != TAG_FORM && gather_n != TAG_LIST && gather_n != TAG_CAT) begin
              fin_d             = 1'b1;
              res_valid_o       = 1'b1;
              res_o.record_kind = KIND_REJECTED;
              res_o.tag_word    = gather_n;
            end else begin
              tag_d   = gather_n;
              phase_d = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          if (pos_n == POS_W'(7)) begin
            size_d = gather_n;
            if (len_q < TYPED_HDR_LEN) begin
              res_valid_o       = 1'b1;
              res_o.record_kind = KIND_HEADER;
              res_o.tag_word    = tag_q;
              res_o.size_word   = gather_n;
              // chunk scan opens at byte 8 if the file is longer than 16 bytes
              next_d = NEXT_W'(8);
              if (LEN_W'(16) < len_q) phase_d = PH_SCAN;
              else                    fin_d   = 1'b1;
            end
          end else if (pos_n == POS_W'(11)) begin
            res_valid_o        = 1'b1;
            res_o.record_kind  = KIND_HEADER;
            res_o.tag_word     = tag_q;
            res_o.size_word    = size_q;
            res_o.form_type    = gather_n;
            res_o.type_present = 1'b1;
            next_d = NEXT_W'(12);
            if (LEN_W'(20) < len_q) phase_d = PH_SCAN;
            else                    fin_d   = 1'b1;
          end
        end
        PH_SCAN: begin
          if (pos_ext == next_p3) begin
            tag_d = gather_n;
          end else if (pos_ext == next_p7) begin
            size_d            = gather_n;
            res_valid_o       = 1'b1;
            res_o.record_kind = KIND_CHUNK;
            res_o.tag_word    = tag_q;
            res_o.size_word   = gather_n;
            res_o.data_offset = next_p8[OFFS_W-1:0];
            // skip the chunk body, no pad byte
            next_d = new_next[NEXT_W-1:0];
            if (tag_q == TAG_FORM || !(new_next_p8 < len_ext)) fin_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      fin_q    <= 1'b0;
      pos_q    <= '0;
      next_q   <= '0;
      gather_q <= '0;
      tag_q    <= '0;
      size_q   <= '0;
      len_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      pos_q    <= pos_d;
      next_q   <= next_d;
      gather_q <= gather_d;
      tag_q    <= tag_d;
      size_q   <= size_d;
      if (cfg_we_i) len_q <= cfg_wdata_i[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/iffd_outbuf.sv
`default_nettype none

module iffd_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  iffd_pkg::out_item_t   push_item_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output iffd_pkg::out_item_t   out_item_o
);
  import iffd_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      slot_free;

  // push arrives only while the skid stage is empty
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = push_item_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      // hold the waiting result, park the new one
      skid_d       = push_item_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### sv/iffd_checker.sv
`default_nettype none

module iffd_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_stall_o,
  input  wire logic             out_valid_o,
  input  wire logic             out_stall_i,
  input  iffd_pkg::out_item_t   out_item_o
);
  import iffd_pkg::*;

  // a held result keeps its valid and its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("held result changed");

  // input backs up only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.record_kind != 2'd3)
    else $error("bad record kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.record_kind == KIND_REJECTED |->
      out_item_o.size_word == '0 && out_item_o.form_type == '0 &&
      !out_item_o.type_present && out_item_o.data_offset == '0)
    else $error("rejected record carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.record_kind == KIND_CHUNK |->
      out_item_o.form_type == '0 && !out_item_o.type_present)
    else $error("chunk record carries a form type");

endmodule

bind iff_chunk_deframer iffd_checker u_iffd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
